>>> rtl/core/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text cell glyph row renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcgr_pkg;

    typedef enum logic [1:0] {
        OP_RENDER   = 2'd0,
        OP_WR_WIDTH = 2'd1,
        OP_WR_ROW   = 2'd2
    } t_opcode;

    typedef enum logic {
        CFG_CELL_WIDTH  = 1'b0,
        CFG_CELL_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic rd_en;
        logic wr_width;
        logic wr_row;
    } t_font_ctl;

    localparam logic [15:0] OVERLAY_MARK      = 16'hffff;
    localparam logic [4:0]  WIDTH_LIMIT       = 5'd16;
    localparam logic [4:0]  MAX_COLS          = 5'd16;
    localparam logic [4:0]  CELL_WIDTH_RESET  = 5'd8;
    localparam logic [4:0]  CELL_HEIGHT_RESET = 5'd16;
    localparam int          PIXEL_COUNT       = 16;

endpackage

`default_nettype wire

>>> rtl/core/tcgr_font_store.sv
// ----------------------------------------------------------------------------
// tcgr_font_store
// Font memories: glyph widths and glyph rows, with registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_font_store #(
    parameter int GLYPH_COUNT = 256,
    parameter int MAX_ROWS    = 16
) (
    input  wire logic                i_clk,
    input  wire tcgr_pkg::t_font_ctl i_ctl,
    input  wire logic [7:0]          i_wr_code,
    input  wire logic [7:0]          i_rd_code,
    input  wire logic [3:0]          i_row,
    input  wire logic [15:0]         i_data,
    output logic      [15:0]         o_rd_bits,
    output logic      [4:0]          o_rd_width
);

    localparam int GA_W  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int DEPTH = GLYPH_COUNT * MAX_ROWS;
    localparam int RA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [15:0]     r_rows   [DEPTH];
    logic [4:0]      r_widths [GLYPH_COUNT];
    logic [15:0]     r_rd_bits;
    logic [4:0]      r_rd_width;

    logic [GA_W-1:0] wr_glyph;
    logic [GA_W-1:0] rd_glyph;
    logic [RA_W-1:0] wr_addr;
    logic [RA_W-1:0] rd_addr;
    logic [4:0]      wr_width_val;

    always_comb begin
        wr_glyph = i_wr_code[GA_W-1:0];
        rd_glyph = i_rd_code[GA_W-1:0];
        wr_addr  = RA_W'(wr_glyph) * RA_W'(MAX_ROWS) + RA_W'(i_row);
        rd_addr  = RA_W'(rd_glyph) * RA_W'(MAX_ROWS) + RA_W'(i_row);
        if (i_data > 16'(tcgr_pkg::WIDTH_LIMIT)) begin
            wr_width_val = tcgr_pkg::WIDTH_LIMIT;
        end else begin
            wr_width_val = i_data[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_row) begin
            r_rows[wr_addr] <= i_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_bits <= r_rows[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_width) begin
            r_widths[wr_glyph] <= wr_width_val;
        end
        if (i_ctl.rd_en) begin
            r_rd_width <= r_widths[rd_glyph];
        end
    end

    assign o_rd_bits  = r_rd_bits;
    assign o_rd_width = r_rd_width;

endmodule

`default_nettype wire

>>> rtl/core/text_cell_glyph_row_render_core.sv
// ----------------------------------------------------------------------------
// text_cell_glyph_row_render_core
// Character generator that turns a text cell and a row number into one row
// of 4-bit pixel colors from a writable font store.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_ready   opcode, cell_req, code, row, data
//   out       output     o_out_valid / i_out_ready pixels, use_overlay
//   cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One item is accepted per cycle unless a stalled output holds a full middle
// stage; a render result passes the registered font read, then the result register.
// Write operations finish at their transfer and produce no result.
// Reset empties the pipeline and restores the cell size registers; the font
// memories keep their contents. A stalled output holds the pipeline, and the
// input stays ready while the middle stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_glyph_row_render_core #(
    parameter int GLYPH_COUNT = 256,
    parameter int MAX_ROWS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_cell_req,
    input  wire logic [7:0]  i_glyph_code,
    input  wire logic [3:0]  i_row,
    input  wire logic [15:0] i_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [63:0] o_pixels,
    output logic             o_use_overlay,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [4:0]  i_cfg_data
);

    logic [4:0]          r_cell_width;
    logic [4:0]          r_cell_height;

    logic                r_s1_valid;
    logic                r_s1_overlay;
    logic                r_s1_blank;
    logic                r_s1_nochar;
    logic [3:0]          r_s1_fg;
    logic [3:0]          r_s1_bg;

    logic                r_out_valid;
    logic [63:0]         r_pixels;
    logic                r_overlay;

    logic                in_xfer;
    logic                out_free;
    logic                code_ok;
    logic                char_ok;
    logic                row_ok;
    logic                is_render;
    tcgr_pkg::t_font_ctl font_ctl;
    logic [15:0]         rd_bits;
    logic [4:0]          rd_width;

    logic [4:0]          cw;
    logic [4:0]          gw;
    logic [4:0]          shift;
    logic [15:0]         bits;
    logic [15:0]         placed;
    logic [63:0]         n_pixels;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        code_ok   = {1'b0, i_glyph_code} < 9'(GLYPH_COUNT);
        char_ok   = {1'b0, i_cell_req[7:0]} < 9'(GLYPH_COUNT);
        row_ok    = 6'(i_row) < 6'(MAX_ROWS);
        is_render = 1'b0;
        font_ctl  = '0;
        case (tcgr_pkg::t_opcode'(i_opcode))
            tcgr_pkg::OP_RENDER: begin
                is_render      = in_xfer;
                font_ctl.rd_en = in_xfer;
            end
            tcgr_pkg::OP_WR_WIDTH: begin
                font_ctl.wr_width = in_xfer && code_ok;
            end
            tcgr_pkg::OP_WR_ROW: begin
                font_ctl.wr_row = in_xfer && code_ok && row_ok;
            end
            default: begin
                font_ctl = '0;
            end
        endcase
    end

    tcgr_font_store #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .MAX_ROWS    (MAX_ROWS)
    ) u_font_store (
        .i_clk      (i_clk),
        .i_ctl      (font_ctl),
        .i_wr_code  (i_glyph_code),
        .i_rd_code  (i_cell_req[7:0]),
        .i_row      (i_row),
        .i_data     (i_data),
        .o_rd_bits  (rd_bits),
        .o_rd_width (rd_width)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= tcgr_pkg::CELL_WIDTH_RESET;
            r_cell_height <= tcgr_pkg::CELL_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (tcgr_pkg::t_cfg_idx'(i_cfg_idx))
                tcgr_pkg::CFG_CELL_WIDTH:  r_cell_width  <= i_cfg_data;
                tcgr_pkg::CFG_CELL_HEIGHT: r_cell_height <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= is_render;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_render) begin
            r_s1_overlay <= i_cell_req == tcgr_pkg::OVERLAY_MARK;
            r_s1_blank   <= ({1'b0, i_row} >= r_cell_height) || !row_ok;
            r_s1_nochar  <= !char_ok;
            r_s1_fg      <= i_cell_req[11:8];
            r_s1_bg      <= i_cell_req[15:12];
        end
    end

    always_comb begin
        cw    = (r_cell_width > tcgr_pkg::MAX_COLS) ? tcgr_pkg::MAX_COLS : r_cell_width;
        gw    = r_s1_nochar ? 5'd0 : rd_width;
        bits  = r_s1_nochar ? 16'd0 : rd_bits;
        shift = (gw < cw) ? ((cw - gw) >> 1) : 5'd0;
        placed = bits << shift;
        n_pixels = '0;
        for (int j = 0; j < tcgr_pkg::PIXEL_COUNT; j++) begin
            if (5'(j) < cw) begin
                n_pixels[4*j +: 4] = placed[j] ? r_s1_fg : r_s1_bg;
            end
        end
        if (r_s1_overlay || r_s1_blank) begin
            n_pixels = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_pixels  <= n_pixels;
            r_overlay <= r_s1_overlay;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixels      = r_pixels;
    assign o_use_overlay = r_overlay;

endmodule

`default_nettype wire

>>> rtl/core/tcgr_checker.sv
// ----------------------------------------------------------------------------
// tcgr_checker
// Port-level checks of the text cell glyph row renderer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_pixels,
    input wire logic        o_use_overlay
);

    // The input side only stalls when a result is waiting and not taken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    // An overlay result never carries pixel data.
    a_overlay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_use_overlay) |-> (o_pixels == 64'd0))
        else $error("overlay result with nonzero pixels");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A waiting result holds its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_pixels) && $stable(o_use_overlay)))
        else $error("stalled result changed");

endmodule

bind text_cell_glyph_row_render_core tcgr_checker u_tcgr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixels      (o_pixels),
    .o_use_overlay (o_use_overlay)
);

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text cell glyph row renderer. It loads glyph
// widths and rows, renders cell rows under several cell sizes and idle
// patterns, and compares every result with an in-bench font and pixel model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_IGNORED     = 2'd3;
    localparam int         LATENCY_CYCLES = 4;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASE_ITEMS    = 100;

    typedef struct {
        logic [63:0] pixels;
        logic        use_overlay;
    } t_row_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_cell_req = '0;
    logic [7:0]  i_glyph_code = '0;
    logic [3:0]  i_row = '0;
    logic [15:0] i_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_pixels;
    logic        o_use_overlay;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = tcgr_pkg::CFG_CELL_WIDTH;
    logic [4:0]  i_cfg_data = '0;

    text_cell_glyph_row_render_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Font and cell size as the block should hold them.
    logic [15:0] font_rows [256][16];
    logic [4:0]  glyph_wid [256];
    logic [4:0]  cell_w = tcgr_pkg::CELL_WIDTH_RESET;
    logic [4:0]  cell_h = tcgr_pkg::CELL_HEIGHT_RESET;
    t_row_result pending_rows [$];
    int          fail_count = 0;

    // Which font entries the stimulus has already written.
    bit          width_known [256];
    bit [15:0]   row_known [256];

    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold = 0;

    function automatic t_row_result render_row(logic [15:0] cell_word, logic [3:0] row_i);
        t_row_result res;
        logic [7:0]  ch;
        logic [15:0] bits;
        int          cw;
        int          gw;
        int          shift;
        int          j;
        res.pixels = '0;
        res.use_overlay = 1'b0;
        if (cell_word == tcgr_pkg::OVERLAY_MARK) begin
            res.use_overlay = 1'b1;
            return res;
        end
        if (row_i >= cell_h) return res;
        ch = cell_word[7:0];
        cw = (cell_w > tcgr_pkg::MAX_COLS) ? tcgr_pkg::MAX_COLS : cell_w;
        gw = glyph_wid[ch];
        bits = font_rows[ch][row_i];
        shift = (gw < cw) ? (cw - gw) / 2 : 0;
        for (j = 0; j < cw; j++) begin
            res.pixels[4*j +: 4] = cell_word[15:12];
            if (j >= shift) begin
                if (bits[j - shift]) res.pixels[4*j +: 4] = cell_word[11:8];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : row_checker
        t_row_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_rows.size() == 0) begin
                    $error("unexpected result: pixels %h use_overlay %b",
                           o_pixels, o_use_overlay);
                    fail_count++;
                end else begin
                    want = pending_rows.pop_front();
                    if (o_pixels !== want.pixels) begin
                        $error("pixels: expected %h, actual %h", want.pixels, o_pixels);
                        fail_count++;
                    end
                    if (o_use_overlay !== want.use_overlay) begin
                        $error("use_overlay: expected %b, actual %b",
                               want.use_overlay, o_use_overlay);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == tcgr_pkg::CFG_CELL_WIDTH) cell_w = i_cfg_data;
                else cell_h = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                case (i_opcode)
                    tcgr_pkg::OP_RENDER:
                        pending_rows.push_back(render_row(i_cell_req, i_row));
                    tcgr_pkg::OP_WR_WIDTH:
                        glyph_wid[i_glyph_code] = (i_data > tcgr_pkg::WIDTH_LIMIT) ?
                                                  tcgr_pkg::WIDTH_LIMIT : i_data[4:0];
                    tcgr_pkg::OP_WR_ROW:
                        font_rows[i_glyph_code][i_row] = i_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [15:0] cell_word,
                             input logic [7:0] code, input logic [3:0] row_i,
                             input logic [15:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_cell_req   <= cell_word;
        i_glyph_code <= code;
        i_row        <= row_i;
        i_data       <= data;
        if (op == tcgr_pkg::OP_WR_WIDTH) width_known[code] = 1'b1;
        if (op == tcgr_pkg::OP_WR_ROW) row_known[code][row_i] = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cell_size(input logic [4:0] w, input logic [4:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tcgr_pkg::CFG_CELL_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= tcgr_pkg::CFG_CELL_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [4:0] pick_cell_dim();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 5'($urandom_range(31));
        if (r == 1) return 5'd16;
        return 5'($urandom_range(16, 1));
    endfunction

    function automatic logic [15:0] pick_width_data();
        if ($urandom_range(3) == 0) return 16'($urandom_range(65535));
        return 16'($urandom_range(20));
    endfunction

    function automatic logic [15:0] pick_row_bits();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hffff;
        return 16'($urandom_range(65535));
    endfunction

    // A render reads the width and the addressed row of its glyph, so both
    // are loaded first when the font does not hold them yet.
    task automatic load_glyph(input logic [7:0] ch, input logic [3:0] row_i);
        if (!width_known[ch])
            send_item(tcgr_pkg::OP_WR_WIDTH, 16'($urandom), ch, 4'($urandom),
                      pick_width_data());
        if (!row_known[ch][row_i])
            send_item(tcgr_pkg::OP_WR_ROW, 16'($urandom), ch, row_i, pick_row_bits());
    endtask

    task automatic random_render();
        logic [15:0] cell_word;
        logic [3:0]  row_i;
        cell_word = 16'($urandom_range(65535));
        row_i = 4'($urandom_range(15));
        load_glyph(cell_word[7:0], row_i);
        send_item(tcgr_pkg::OP_RENDER, cell_word, 8'($urandom), row_i, 16'($urandom));
    endtask

    task automatic random_item();
        int          sel;
        logic [3:0]  row_i;
        sel = $urandom_range(99);
        row_i = 4'($urandom_range(15));
        if (sel < 55) begin
            random_render();
        end else if (sel < 62) begin
            load_glyph(tcgr_pkg::OVERLAY_MARK[7:0], row_i);
            send_item(tcgr_pkg::OP_RENDER, tcgr_pkg::OVERLAY_MARK, 8'($urandom), row_i,
                      16'($urandom));
        end else if (sel < 75) begin
            send_item(tcgr_pkg::OP_WR_WIDTH, 16'($urandom), 8'($urandom), row_i,
                      pick_width_data());
        end else if (sel < 95) begin
            send_item(tcgr_pkg::OP_WR_ROW, 16'($urandom), 8'($urandom), row_i,
                      pick_row_bits());
        end else begin
            send_item(OP_IGNORED, 16'($urandom), 8'($urandom), row_i, 16'($urandom));
        end
    endtask

    task automatic test_font_basics();
        send_item(tcgr_pkg::OP_WR_WIDTH, 16'h0000, 8'h00, 4'h0, 16'd0);
        send_item(tcgr_pkg::OP_WR_WIDTH, 16'h0000, 8'hff, 4'h0, 16'd16);
        send_item(tcgr_pkg::OP_WR_WIDTH, 16'h0000, 8'h41, 4'h0, 16'd5);
        send_item(tcgr_pkg::OP_WR_WIDTH, 16'h0000, 8'h80, 4'h0, 16'd17);
        send_item(tcgr_pkg::OP_WR_WIDTH, 16'h0000, 8'h01, 4'hf, 16'hffff);
        send_item(tcgr_pkg::OP_WR_ROW, 16'h0000, 8'h00, 4'h0, 16'hffff);
        send_item(tcgr_pkg::OP_WR_ROW, 16'h0000, 8'h00, 4'hf, 16'h0000);
        send_item(tcgr_pkg::OP_WR_ROW, 16'h0000, 8'hff, 4'h0, 16'hffff);
        send_item(tcgr_pkg::OP_WR_ROW, 16'h0000, 8'hff, 4'hf, 16'h0000);
        send_item(tcgr_pkg::OP_WR_ROW, 16'h0000, 8'h41, 4'h0, 16'haaaa);
        send_item(tcgr_pkg::OP_WR_ROW, 16'h0000, 8'h41, 4'hf, 16'h5555);
        send_item(tcgr_pkg::OP_WR_ROW, 16'h0000, 8'h80, 4'h3, 16'h8001);
        send_item(tcgr_pkg::OP_WR_ROW, 16'h0000, 8'h01, 4'h7, 16'hffff);
        send_item(tcgr_pkg::OP_RENDER, 16'hf000, 8'h00, 4'h0, 16'h0000);
        send_item(tcgr_pkg::OP_RENDER, 16'h0fff, 8'h00, 4'h0, 16'h0000);
        send_item(tcgr_pkg::OP_RENDER, 16'h0f00, 8'h00, 4'hf, 16'h0000);
        send_item(tcgr_pkg::OP_RENDER, tcgr_pkg::OVERLAY_MARK, 8'h00, 4'h0, 16'h0000);
        send_item(tcgr_pkg::OP_RENDER, tcgr_pkg::OVERLAY_MARK, 8'hff, 4'hf, 16'hffff);
        send_item(tcgr_pkg::OP_RENDER, 16'h5a41, 8'h00, 4'h0, 16'h0000);
        send_item(tcgr_pkg::OP_RENDER, 16'ha541, 8'h00, 4'hf, 16'h0000);
        send_item(tcgr_pkg::OP_RENDER, 16'h3c80, 8'h00, 4'h3, 16'h0000);
        send_item(OP_IGNORED, 16'hffff, 8'hff, 4'hf, 16'hffff);
        send_item(tcgr_pkg::OP_RENDER, 16'h9601, 8'h00, 4'h7, 16'h0000);
        wait_drain();
    endtask

    task automatic test_cell_sizes();
        logic [4:0] widths [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16, 5'd3};
        logic [4:0] heights [8] = '{5'd16, 5'd1, 5'd16, 5'd31, 5'd4, 5'd0, 5'd1, 5'd12};
        for (int k = 0; k < 8; k++) begin
            write_cell_size(widths[k], heights[k]);
            send_item(tcgr_pkg::OP_RENDER, 16'h5a41, 8'h00, 4'h0, 16'h0000);
            send_item(tcgr_pkg::OP_RENDER, 16'h0fff, 8'h00, 4'hf, 16'h0000);
            send_item(tcgr_pkg::OP_RENDER, 16'h3c80, 8'h00, 4'h3, 16'h0000);
            repeat (8) random_render();
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        write_cell_size(pick_cell_dim(), pick_cell_dim());
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        @(posedge i_clk);
        rx_hold <= HOLD_CYCLES;
        repeat (40) random_render();
        wait_drain();
        repeat (20) random_render();
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int tx_pct [4] = '{0, 80, 0, 32};
        int rx_pct [4] = '{0, 0, 80, 32};
        for (int p = 0; p < 4; p++) begin
            write_cell_size(pick_cell_dim(), pick_cell_dim());
            tx_idle_pct = tx_pct[p];
            rx_stall_pct <= rx_pct[p];
            repeat (PHASE_ITEMS) random_item();
            wait_drain();
        end
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_font_basics();
        test_cell_sizes();
        test_backpressure();
        test_random_traffic();
        wait_drain();
        repeat (4 * LATENCY_CYCLES) @(posedge i_clk);
        if (pending_rows.size() != 0) begin
            $error("%0d expected results never arrived", pending_rows.size());
            fail_count += pending_rows.size();
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
